/* rtl/core/ltmi_pkg.sv */
package ltmi_pkg;

    localparam int IDX_W = 54;
    localparam int EXT_W = 31;
    localparam int AX_W = 3;
    localparam int SLOTS = 6;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_LOW    = 2'd1,
        ST_ZERO   = 2'd2,
        ST_BEYOND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        REG_DIMS = 3'd0,
        REG_EXT0 = 3'd1,
        REG_EXT5 = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic                             valid;
        status_t                          status;
        logic [AX_W-1:0]                  axis;
        logic [IDX_W-1:0]                 x;
        logic [EXT_W-1:0]                 rem;
        logic [SLOTS-1:0][EXT_W-1:0]      coords;
    } beat_t;

endpackage

/* rtl/core/ltmi_cell.sv */
module ltmi_cell
    import ltmi_pkg::*;
#(
    parameter int AXIS = 0,
    parameter int BIT  = 0
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic             active,
    input  logic [EXT_W-1:0] divisor,
    input  beat_t            beat_in,
    output beat_t            beat_out
);

    beat_t          beat_next;
    beat_t          beat_reg;
    logic           valid_reg;
    logic [EXT_W:0] trial;
    logic [EXT_W:0] diff;
    logic           ge;

    // one restoring division step per cell
    always_comb
    begin
        beat_next = beat_in;
        trial     = {beat_in.rem, beat_in.x[BIT]};
        ge        = (trial >= {1'b0, divisor});
        diff      = trial - {1'b0, divisor};
        if (active && beat_in.status == ST_OK)
        begin
            beat_next.x[BIT] = ge;
            if (BIT == 0)
            begin
                beat_next.coords[AXIS] = (ge ? diff[EXT_W-1:0] : trial[EXT_W-1:0])
                                         + EXT_W'(1);
                beat_next.rem = '0;
            end
            else
            begin
                beat_next.rem = ge ? diff[EXT_W-1:0] : trial[EXT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= beat_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            beat_reg <= beat_next;
        end
    end

    always_comb
    begin
        beat_out       = beat_reg;
        beat_out.valid = valid_reg;
    end

endmodule

/* rtl/core/ltmi_emit.sv */
module ltmi_emit
    import ltmi_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  beat_t            tail,
    input  logic [AX_W-1:0]  n_used,
    output logic             adv,
    output logic             done,
    output logic [EXT_W-1:0] coordinate,
    output logic [AX_W-1:0]  axis,
    output logic             last,
    output logic [1:0]       status
);

    logic [AX_W-1:0]             cnt_reg;
    logic [AX_W-1:0]             cnt_next;
    logic [AX_W-1:0]             pos_reg;
    logic [AX_W-1:0]             pos_next;
    logic [AX_W-1:0]             ax_reg;
    logic [AX_W-1:0]             ax_next;
    status_t                     st_reg;
    status_t                     st_next;
    logic [SLOTS-1:0][EXT_W-1:0] coords_reg;
    logic                        load;

    assign load = tail.valid && (cnt_reg <= AX_W'(1));
    assign adv  = !tail.valid || (cnt_reg <= AX_W'(1));

    always_comb
    begin
        cnt_next = cnt_reg;
        pos_next = pos_reg;
        ax_next  = ax_reg;
        st_next  = st_reg;
        if (load)
        begin
            pos_next = '0;
            st_next  = tail.status;
            ax_next  = tail.axis;
            cnt_next = AX_W'(1);
            if (tail.status == ST_OK)
            begin
                if (tail.x != '0)
                begin
                    st_next = ST_BEYOND;
                    ax_next = n_used - AX_W'(1);
                end
                else
                begin
                    cnt_next = n_used;
                end
            end
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - AX_W'(1);
            pos_next = pos_reg + AX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            pos_reg <= '0;
            ax_reg  <= '0;
            st_reg  <= ST_OK;
        end
        else
        begin
            cnt_reg <= cnt_next;
            pos_reg <= pos_next;
            ax_reg  <= ax_next;
            st_reg  <= st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            coords_reg <= tail.coords;
        end
    end

    assign done       = (cnt_reg != '0);
    assign coordinate = (st_reg == ST_OK) ? coords_reg[pos_reg] : '0;
    assign axis       = (st_reg == ST_OK) ? pos_reg : ax_reg;
    assign last       = (cnt_reg == AX_W'(1));
    assign status     = st_reg;

`ifndef SYNTH
    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != ST_OK |-> last)
        else $error("error beat not marked last");
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != ST_OK |-> coordinate == '0)
        else $error("error beat with coordinate");
    a_run_on: assert property (@(posedge clk) disable iff (!rst_n)
        done && !last |=> done && axis == $past(axis) + AX_W'(1))
        else $error("result run broken");
`endif

endmodule

/* rtl/core/linear_to_multi_index_top.sv */
// path from start to the first result beat: every division cell register, then the result port registers
// one division cell per quotient bit per dimension, 54 cells per dimension
// throughput: one index per cycle for errors and single-dimension setups,
// otherwise busy stalls new indices while the single result port emits one beat per used dimension
// the receiver cannot stall; results stream one beat per cycle
// reset: num_dims 1, all extents 1, pipeline and result port empty
module linear_to_multi_index_top
    import ltmi_pkg::*;
#(
    parameter int MAX_DIMS = 6
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [2:0]       cfg_addr,
    input  logic [EXT_W-1:0] cfg_wdata,
    input  logic             start,
    output logic             busy,
    input  logic [IDX_W-1:0] linear_index,
    output logic             done,
    output logic [EXT_W-1:0] coordinate,
    output logic [AX_W-1:0]  axis,
    output logic             last,
    output logic [1:0]       status
);

    localparam int NCELL = MAX_DIMS * IDX_W;

    logic [AX_W-1:0]             dims_reg;
    logic [SLOTS-1:0][EXT_W-1:0] ext_reg;
    logic [AX_W-1:0]             n_used;
    logic                        adv;
    beat_t                       entry;
    beat_t                       chain [NCELL+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dims_reg <= AX_W'(1);
            for (int i = 0; i < SLOTS; i++)
            begin
                ext_reg[i] <= EXT_W'(1);
            end
        end
        else if (cfg_we)
        begin
            if (cfg_addr == REG_DIMS)
            begin
                dims_reg <= cfg_wdata[AX_W-1:0];
            end
            else if (cfg_addr >= REG_EXT0 && cfg_addr <= REG_EXT5)
            begin
                ext_reg[cfg_addr - REG_EXT0] <= cfg_wdata;
            end
        end
    end

    always_comb
    begin
        if (dims_reg == '0)
        begin
            n_used = AX_W'(1);
        end
        else if (dims_reg > AX_W'(MAX_DIMS))
        begin
            n_used = AX_W'(MAX_DIMS);
        end
        else
        begin
            n_used = dims_reg;
        end
    end

    assign busy = !adv;

    always_comb
    begin
        entry        = '0;
        entry.valid  = start && adv;
        entry.x      = linear_index - IDX_W'(1);
        entry.status = ST_OK;
        if (linear_index == '0)
        begin
            entry.status = ST_LOW;
        end
        else
        begin
            for (int a = MAX_DIMS - 1; a >= 0; a--)
            begin
                if (AX_W'(a) < n_used && ext_reg[a] == '0)
                begin
                    entry.status = ST_ZERO;
                    entry.axis   = AX_W'(a);
                end
            end
        end
    end

    assign chain[0] = entry;

    for (genvar a = 0; a < MAX_DIMS; a++)
    begin : g_dim
        for (genvar b = 0; b < IDX_W; b++)
        begin : g_bit
            ltmi_cell #(
                .AXIS (a),
                .BIT  (IDX_W - 1 - b)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .adv      (adv),
                .active   (AX_W'(a) < n_used),
                .divisor  (ext_reg[a]),
                .beat_in  (chain[a*IDX_W + b]),
                .beat_out (chain[a*IDX_W + b + 1])
            );
        end
    end

    ltmi_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .tail       (chain[NCELL]),
        .n_used     (n_used),
        .adv        (adv),
        .done       (done),
        .coordinate (coordinate),
        .axis       (axis),
        .last       (last),
        .status     (status)
    );

endmodule
